>>> src/dual_moving_average_crossover_macros.svh
// Assertion macros for the checker file, dmac_checker.sv.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DUAL_MOVING_AVERAGE_CROSSOVER_MACROS_SVH
`define DUAL_MOVING_AVERAGE_CROSSOVER_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define DMAC_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after the condition.
`define DMAC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> src/dmac_pkg.sv
`default_nettype none

package dmac_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int PRICE_BITS = 32;

    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = PRICE_BITS + ADDR_W;
    localparam int PROD_W     = SUM_W + CNT_W;
    localparam int CFG_W      = 9;
    localparam int IDX_W      = 2;
    localparam int TAG_W      = 32;
    localparam int IN_PRICE_W = 32;

    localparam logic [IDX_W-1:0] REG_SHORT_WINDOW = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_LONG_WINDOW  = IDX_W'(1);

    localparam logic [CFG_W-1:0] SHORT_WINDOW_RESET = CFG_W'(5);
    localparam logic [CFG_W-1:0] LONG_WINDOW_RESET  = CFG_W'(20);

    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_WINDOW);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_WINDOW - 1);

    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REL_EQUAL = 2'd0,
        REL_ABOVE = 2'd1,
        REL_BELOW = 2'd2
    } rel_t;

    typedef struct packed {
        logic [TAG_W-1:0]      day_tag;
        logic [IN_PRICE_W-1:0] close_price;
        logic [SUM_W-1:0]      short_sum;
        logic [SUM_W-1:0]      long_sum;
        logic [CNT_W-1:0]      short_len;
        logic [CNT_W-1:0]      long_len;
        logic                  long_filled;
    } sums_t;

    // A window of zero counts as one, and a window above the ring depth saturates.
    function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] w);
        logic [CNT_W-1:0] len;
        if (w == '0) begin
            len = CNT_W'(1);
        end
        else if (int'(w) > MAX_WINDOW) begin
            len = CNT_MAX;
        end
        else begin
            len = CNT_W'(w);
        end
        return len;
    endfunction

    function automatic logic [PRICE_BITS-1:0] price_bits(input logic [IN_PRICE_W-1:0] p);
        logic [63:0] wide;
        wide = {32'b0, p};
        return wide[PRICE_BITS-1:0];
    endfunction

    // Ring slot that lies w places behind wp.
    function automatic logic [ADDR_W-1:0] ring_back(input logic [ADDR_W-1:0] wp,
                                                    input logic [CNT_W-1:0] w);
        int diff;
        diff = int'(wp) - int'(w);
        if (diff < 0) begin
            diff = diff + MAX_WINDOW;
        end
        return ADDR_W'(diff);
    endfunction

endpackage

`default_nettype wire

>>> src/dmac_ram.sv
`default_nettype none

module dmac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/dmac_window.sv
`default_nettype none

module dmac_window (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [dmac_pkg::IN_PRICE_W-1:0]     close_price,
    input  wire logic [dmac_pkg::TAG_W-1:0]          day_tag,
    input  wire logic [dmac_pkg::CNT_W-1:0]          short_len,
    input  wire logic [dmac_pkg::CNT_W-1:0]          long_len,
    input  wire logic                                down_ready,
    output logic                                     sums_valid,
    output dmac_pkg::sums_t                          sums
);

    // The ring holds running totals of all prices, so a window sum is a difference.
    logic                              accept;
    logic                              en1;
    logic                              en2;

    logic [dmac_pkg::SUM_W-1:0]        total_reg;
    logic [dmac_pkg::SUM_W-1:0]        total_next;
    logic [dmac_pkg::ADDR_W-1:0]       wp_reg;
    logic [dmac_pkg::ADDR_W-1:0]       wp_next;
    logic [dmac_pkg::CNT_W-1:0]        seen_reg;
    logic [dmac_pkg::CNT_W-1:0]        seen_next;
    logic                              beyond_reg;
    logic                              beyond_next;
    logic [dmac_pkg::ADDR_W-1:0]       rd_addr_s;
    logic [dmac_pkg::ADDR_W-1:0]       rd_addr_l;
    logic [dmac_pkg::SUM_W-1:0]        rd_s;
    logic [dmac_pkg::SUM_W-1:0]        rd_l;

    logic                              v1_reg;
    logic [dmac_pkg::TAG_W-1:0]        tag1_reg;
    logic [dmac_pkg::IN_PRICE_W-1:0]   price1_reg;
    logic [dmac_pkg::SUM_W-1:0]        total1_reg;
    logic [dmac_pkg::CNT_W-1:0]        slen1_reg;
    logic [dmac_pkg::CNT_W-1:0]        llen1_reg;
    logic                              sfill1_reg;
    logic                              lfill1_reg;
    logic                              sfirst1_reg;
    logic                              lfirst1_reg;

    logic                              v2_reg;
    dmac_pkg::sums_t                   sums_reg;
    dmac_pkg::sums_t                   sums_next;

    assign en2      = !v2_reg || down_ready;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;
    assign accept   = in_valid && en1;

    assign total_next  = total_reg
                       + dmac_pkg::SUM_W'(dmac_pkg::price_bits(close_price));
    assign wp_next     = (wp_reg == dmac_pkg::ADDR_LAST) ? '0 : wp_reg + 1'b1;
    assign seen_next   = (seen_reg == dmac_pkg::CNT_MAX) ? seen_reg : seen_reg + 1'b1;
    assign beyond_next = beyond_reg || (seen_reg == dmac_pkg::CNT_MAX);
    assign rd_addr_s   = dmac_pkg::ring_back(wp_reg, short_len);
    assign rd_addr_l   = dmac_pkg::ring_back(wp_reg, long_len);

    dmac_ram #(
        .WIDTH (dmac_pkg::SUM_W),
        .DEPTH (dmac_pkg::MAX_WINDOW)
    ) u_ram_short (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (total_next),
        .rd_en   (accept),
        .rd_addr (rd_addr_s),
        .rd_data (rd_s)
    );

    dmac_ram #(
        .WIDTH (dmac_pkg::SUM_W),
        .DEPTH (dmac_pkg::MAX_WINDOW)
    ) u_ram_long (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data (total_next),
        .rd_en   (accept),
        .rd_addr (rd_addr_l),
        .rd_data (rd_l)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            wp_reg     <= '0;
            seen_reg   <= '0;
            beyond_reg <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                total_reg  <= total_next;
                wp_reg     <= wp_next;
                seen_reg   <= seen_next;
                beyond_reg <= beyond_next;
            end
            if (en1)
            begin
                v1_reg <= accept;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag1_reg    <= day_tag;
            price1_reg  <= close_price;
            total1_reg  <= total_next;
            slen1_reg   <= short_len;
            llen1_reg   <= long_len;
            sfill1_reg  <= seen_next >= short_len;
            lfill1_reg  <= seen_next >= long_len;
            sfirst1_reg <= (seen_next == short_len) && !beyond_next;
            lfirst1_reg <= (seen_next == long_len) && !beyond_next;
        end
        if (v1_reg && en2)
        begin
            sums_reg <= sums_next;
        end
    end

    always_comb
    begin
        sums_next.day_tag     = tag1_reg;
        sums_next.close_price = price1_reg;
        sums_next.short_len   = slen1_reg;
        sums_next.long_len    = llen1_reg;
        sums_next.long_filled = lfill1_reg;
        if (!sfill1_reg)
        begin
            sums_next.short_sum = '0;
        end
        else if (sfirst1_reg)
        begin
            sums_next.short_sum = total1_reg;
        end
        else
        begin
            sums_next.short_sum = total1_reg - rd_s;
        end
        if (!lfill1_reg)
        begin
            sums_next.long_sum = '0;
        end
        else if (lfirst1_reg)
        begin
            sums_next.long_sum = total1_reg;
        end
        else
        begin
            sums_next.long_sum = total1_reg - rd_l;
        end
    end

    assign sums_valid = v2_reg;
    assign sums       = sums_reg;

endmodule

`default_nettype wire

>>> src/dmac_signal.sv
`default_nettype none

module dmac_signal (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              sums_valid,
    input  wire dmac_pkg::sums_t                   sums,
    output logic                                   ready,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [dmac_pkg::TAG_W-1:0]             day_tag_out,
    output logic [dmac_pkg::IN_PRICE_W-1:0]        close_price_out,
    output logic [1:0]                             action
);

    logic                              en_out;
    logic                              v3_reg;
    logic [dmac_pkg::PROD_W-1:0]       prod_a_reg;
    logic [dmac_pkg::PROD_W-1:0]       prod_b_reg;
    logic [dmac_pkg::PROD_W-1:0]       prod_a_next;
    logic [dmac_pkg::PROD_W-1:0]       prod_b_next;
    logic [dmac_pkg::TAG_W-1:0]        tag3_reg;
    logic [dmac_pkg::IN_PRICE_W-1:0]   price3_reg;
    logic                              lfill3_reg;

    dmac_pkg::rel_t                    rel;
    dmac_pkg::rel_t                    prev_rel_reg;
    logic                              holding_reg;
    logic                              holding_next;
    dmac_pkg::action_t                 action_next;

    logic                              out_valid_reg;
    logic [dmac_pkg::TAG_W-1:0]        tag_out_reg;
    logic [dmac_pkg::IN_PRICE_W-1:0]   price_out_reg;
    dmac_pkg::action_t                 action_reg;

    assign en_out = !out_valid_reg || !out_stall;
    assign ready  = !v3_reg || en_out;

    // The averages are compared by cross-multiplying each sum with the other window.
    assign prod_a_next = {{dmac_pkg::CNT_W{1'b0}}, sums.short_sum}
                       * {{dmac_pkg::SUM_W{1'b0}}, sums.long_len};
    assign prod_b_next = {{dmac_pkg::CNT_W{1'b0}}, sums.long_sum}
                       * {{dmac_pkg::SUM_W{1'b0}}, sums.short_len};

    always_comb
    begin
        if (prod_a_reg > prod_b_reg)
        begin
            rel = dmac_pkg::REL_ABOVE;
        end
        else if (prod_a_reg < prod_b_reg)
        begin
            rel = dmac_pkg::REL_BELOW;
        end
        else
        begin
            rel = dmac_pkg::REL_EQUAL;
        end

        action_next  = dmac_pkg::ACT_HOLD;
        holding_next = holding_reg;
        if (lfill3_reg)
        begin
            if ((rel == dmac_pkg::REL_ABOVE) && (prev_rel_reg != dmac_pkg::REL_ABOVE)
                && !holding_reg)
            begin
                action_next  = dmac_pkg::ACT_BUY;
                holding_next = 1'b1;
            end
            else if ((rel == dmac_pkg::REL_BELOW) && (prev_rel_reg != dmac_pkg::REL_BELOW)
                     && holding_reg)
            begin
                action_next  = dmac_pkg::ACT_SELL;
                holding_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_rel_reg  <= dmac_pkg::REL_EQUAL;
            holding_reg   <= 1'b0;
        end
        else
        begin
            if (ready)
            begin
                v3_reg <= sums_valid;
            end
            if (en_out)
            begin
                out_valid_reg <= v3_reg;
            end
            if (en_out && v3_reg)
            begin
                prev_rel_reg <= rel;
                holding_reg  <= holding_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sums_valid && ready)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            tag3_reg   <= sums.day_tag;
            price3_reg <= sums.close_price;
            lfill3_reg <= sums.long_filled;
        end
        if (en_out && v3_reg)
        begin
            tag_out_reg   <= tag3_reg;
            price_out_reg <= price3_reg;
            action_reg    <= action_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign day_tag_out     = tag_out_reg;
    assign close_price_out = price_out_reg;
    assign action          = action_reg;

endmodule

`default_nettype wire

>>> src/dual_moving_average_crossover.sv
// An accepted word moves through the stage-1, sums, product and output registers.
// Throughput: one word per cycle while out_stall is low; the ring is two copies of
// a one-write one-read memory, both written with the running price total at every
// accepted word. Reset clears the pointers, counters, holding flag and windows
// (short 5, long 20). The ring is not cleared: a read value is used only once written.
`default_nettype none

module dual_moving_average_crossover (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [dmac_pkg::IN_PRICE_W-1:0]   close_price,
    input  wire logic [dmac_pkg::TAG_W-1:0]        day_tag,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [dmac_pkg::TAG_W-1:0]             day_tag_out,
    output logic [dmac_pkg::IN_PRICE_W-1:0]        close_price_out,
    output logic [1:0]                             action,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dmac_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [dmac_pkg::CFG_W-1:0]        cfg_data
);

    logic [dmac_pkg::CFG_W-1:0]  short_cfg_reg;
    logic [dmac_pkg::CFG_W-1:0]  long_cfg_reg;
    logic [dmac_pkg::CNT_W-1:0]  short_len;
    logic [dmac_pkg::CNT_W-1:0]  long_len;
    logic                        sums_valid;
    dmac_pkg::sums_t             sums;
    logic                        sig_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_cfg_reg <= dmac_pkg::SHORT_WINDOW_RESET;
            long_cfg_reg  <= dmac_pkg::LONG_WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dmac_pkg::REG_SHORT_WINDOW: short_cfg_reg <= cfg_data;
                dmac_pkg::REG_LONG_WINDOW:  long_cfg_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign short_len = dmac_pkg::eff_window(short_cfg_reg);
    assign long_len  = dmac_pkg::eff_window(long_cfg_reg);

    dmac_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .close_price (close_price),
        .day_tag     (day_tag),
        .short_len   (short_len),
        .long_len    (long_len),
        .down_ready  (sig_ready),
        .sums_valid  (sums_valid),
        .sums        (sums)
    );

    dmac_signal u_signal (
        .clk             (clk),
        .rst_n           (rst_n),
        .sums_valid      (sums_valid),
        .sums            (sums),
        .ready           (sig_ready),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .day_tag_out     (day_tag_out),
        .close_price_out (close_price_out),
        .action          (action)
    );

endmodule

`default_nettype wire

>>> src/dmac_checker.sv
`default_nettype none
`include "dual_moving_average_crossover_macros.svh"

module dmac_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [dmac_pkg::TAG_W-1:0]        day_tag_out,
    input  wire logic [dmac_pkg::IN_PRICE_W-1:0]   close_price_out,
    input  wire logic [1:0]                        action
);

    // Position implied by the words delivered so far.
    logic holding_reg;
    logic out_take;
    logic out_hold;
    logic buy_take;
    logic sell_take;
    logic [dmac_pkg::TAG_W+dmac_pkg::IN_PRICE_W+1:0] out_word;

    assign out_take  = out_valid && !out_stall;
    assign out_hold  = out_valid && out_stall;
    assign buy_take  = out_take && (action == dmac_pkg::ACT_BUY);
    assign sell_take = out_take && (action == dmac_pkg::ACT_SELL);
    assign out_word  = {day_tag_out, close_price_out, action};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (action == dmac_pkg::ACT_BUY)
            begin
                holding_reg <= 1'b1;
            end
            else if (action == dmac_pkg::ACT_SELL)
            begin
                holding_reg <= 1'b0;
            end
        end
    end

    `DMAC_ASSERT_NEXT(a_out_held, out_hold, out_valid && $stable(out_word), "stalled word changed")
    `DMAC_ASSERT_NOW(a_buy_when_flat, buy_take, !holding_reg, "buy issued while holding")
    `DMAC_ASSERT_NOW(a_sell_when_long, sell_take, holding_reg, "sell issued while not holding")

endmodule

bind dual_moving_average_crossover dmac_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .day_tag_out     (day_tag_out),
    .close_price_out (close_price_out),
    .action          (action)
);

`default_nettype wire

>>> tb/tb_dual_moving_average_crossover.sv
module tb_dual_moving_average_crossover;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHUNKS       = 12;
    localparam int CHUNK_WORDS  = 70;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int PLAN_ROWS    = 27;

    localparam logic [dmac_pkg::IDX_W-1:0] REG_UNUSED_A = dmac_pkg::IDX_W'(2);
    localparam logic [dmac_pkg::IDX_W-1:0] REG_UNUSED_B = dmac_pkg::IDX_W'(3);

    typedef enum logic [1:0] {
        ROW_WORD = 2'd0,
        ROW_CFG  = 2'd1
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [31:0]       a;
        logic [31:0]       b;
        logic              pinned;
        dmac_pkg::action_t act;
    } row_t;

    typedef struct {
        logic [31:0]       tag;
        logic [31:0]       price;
        dmac_pkg::action_t act;
    } outcome_t;

    // Words carry price and tag; register rows carry index and data.
    localparam row_t PLAN [0:PLAN_ROWS-1] = '{
        '{ROW_WORD, 32'h0000_0000, 32'h0000_0000, 1'b1, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'h0000_0001, 32'h0000_0001, 1'b1, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'h8000_0000, 32'h0000_0002, 1'b1, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'h7FFF_FFFF, 32'h0000_0003, 1'b1, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'hFFFF_FFFF, 32'h0000_0004, 1'b1, dmac_pkg::ACT_HOLD},
        '{ROW_CFG, 32'(dmac_pkg::REG_SHORT_WINDOW), 32'd1, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_CFG, 32'(dmac_pkg::REG_LONG_WINDOW), 32'd2, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd100, 32'h0000_0010, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd200, 32'h0000_0011, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd300, 32'h0000_0012, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd50, 32'h0000_0013, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd50, 32'h0000_0014, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd60, 32'h0000_0015, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd60, 32'h0000_0016, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd10, 32'h0000_0017, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_CFG, 32'(dmac_pkg::REG_SHORT_WINDOW), 32'd0, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_CFG, 32'(dmac_pkg::REG_LONG_WINDOW), 32'd0, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd5, 32'h0000_0020, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd7, 32'h0000_0021, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_CFG, 32'(REG_UNUSED_A), 32'h1FF, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_CFG, 32'(REG_UNUSED_B), 32'h155, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'd9, 32'h0000_0022, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_CFG, 32'(dmac_pkg::REG_SHORT_WINDOW), 32'd511, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_CFG, 32'(dmac_pkg::REG_LONG_WINDOW), 32'd256, 1'b0, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'hFFFF_FFFF, 32'hAAAA_5555, 1'b1, dmac_pkg::ACT_HOLD},
        '{ROW_WORD, 32'h0000_0000, 32'h5555_AAAA, 1'b1, dmac_pkg::ACT_HOLD}
    };

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [dmac_pkg::IN_PRICE_W-1:0] close_price = '0;
    logic [dmac_pkg::TAG_W-1:0]      day_tag = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [dmac_pkg::TAG_W-1:0]      day_tag_out;
    logic [dmac_pkg::IN_PRICE_W-1:0] close_price_out;
    logic [1:0]                      action;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dmac_pkg::IDX_W-1:0]      cfg_index = '0;
    logic [dmac_pkg::CFG_W-1:0]      cfg_data = '0;

    logic [31:0]        price_ring [dmac_pkg::MAX_WINDOW];
    logic [7:0]         ring_slot = '0;
    int unsigned        prices_seen = 0;
    logic [8:0]         short_reg = dmac_pkg::SHORT_WINDOW_RESET;
    logic [8:0]         long_reg = dmac_pkg::LONG_WINDOW_RESET;
    dmac_pkg::rel_t     last_rel = dmac_pkg::REL_EQUAL;
    bit                 in_position = 1'b0;

    outcome_t     expected_words [$];
    int unsigned  send_idle_pct = 35;
    int unsigned  recv_idle_pct = 59;
    int unsigned  hold_asks = 0;
    int unsigned  mismatches = 0;
    int unsigned  words_sent = 0;
    int unsigned  buys = 0;
    int unsigned  sells = 0;
    int unsigned  config_writes = 0;
    int unsigned  hold_offs = 0;

    dual_moving_average_crossover dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .close_price     (close_price),
        .day_tag         (day_tag),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .day_tag_out     (day_tag_out),
        .close_price_out (close_price_out),
        .action          (action),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d words still expected", expected_words.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned window_len(input logic [8:0] w);
        int unsigned len;
        if (w == 9'd0)
        begin
            len = 1;
        end
        else if (w > 9'(dmac_pkg::MAX_WINDOW))
        begin
            len = 32'(dmac_pkg::MAX_WINDOW);
        end
        else
        begin
            len = 32'(w);
        end
        return len;
    endfunction

    function automatic logic [39:0] window_total(input int unsigned len);
        logic [39:0] total;
        logic [7:0]  slot;
        total = '0;
        if (prices_seen >= len)
        begin
            for (int unsigned k = 1; k <= len; k++)
            begin
                slot = ring_slot - 8'(k);
                total = total + 40'(price_ring[slot]);
            end
        end
        return total;
    endfunction

    // Stores the price, re-forms both window sums over the ring and applies the
    // crossover rules to decide this day's action.
    function automatic dmac_pkg::action_t advance_crossover(input logic [31:0] price);
        int unsigned       short_len;
        int unsigned       long_len;
        logic [39:0]       short_total;
        logic [39:0]       long_total;
        logic [63:0]       short_side;
        logic [63:0]       long_side;
        dmac_pkg::rel_t    rel;
        dmac_pkg::action_t act;
        short_len = window_len(short_reg);
        long_len = window_len(long_reg);
        price_ring[ring_slot] = price;
        ring_slot = ring_slot + 8'd1;
        if (prices_seen < dmac_pkg::MAX_WINDOW)
        begin
            prices_seen++;
        end
        short_total = window_total(short_len);
        long_total = window_total(long_len);
        short_side = 64'(short_total) * 64'(long_len);
        long_side = 64'(long_total) * 64'(short_len);
        if (short_side > long_side)
        begin
            rel = dmac_pkg::REL_ABOVE;
        end
        else if (short_side < long_side)
        begin
            rel = dmac_pkg::REL_BELOW;
        end
        else
        begin
            rel = dmac_pkg::REL_EQUAL;
        end
        act = dmac_pkg::ACT_HOLD;
        if (prices_seen >= long_len)
        begin
            if (rel == dmac_pkg::REL_ABOVE && last_rel != dmac_pkg::REL_ABOVE
                && !in_position)
            begin
                act = dmac_pkg::ACT_BUY;
                in_position = 1'b1;
            end
            else if (rel == dmac_pkg::REL_BELOW && last_rel != dmac_pkg::REL_BELOW
                     && in_position)
            begin
                act = dmac_pkg::ACT_SELL;
                in_position = 1'b0;
            end
        end
        last_rel = rel;
        return act;
    endfunction

    task automatic send_word(input logic [31:0] price, input logic [31:0] tag,
                             input bit pinned, input dmac_pkg::action_t pinned_act);
        outcome_t          want;
        dmac_pkg::action_t act;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        close_price <= price;
        day_tag <= tag;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        act = advance_crossover(price);
        want.tag = tag;
        want.price = price;
        want.act = pinned ? pinned_act : act;
        expected_words = {expected_words, want};
        words_sent++;
        if (act == dmac_pkg::ACT_BUY)
        begin
            buys++;
        end
        if (act == dmac_pkg::ACT_SELL)
        begin
            sells++;
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [dmac_pkg::IDX_W-1:0] idx,
                                  input logic [dmac_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == dmac_pkg::REG_SHORT_WINDOW)
        begin
            short_reg = val;
        end
        else if (idx == dmac_pkg::REG_LONG_WINDOW)
        begin
            long_reg = val;
        end
        config_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // The long hold-off lets the block fill up and stall its input.
    always
    begin
        @(negedge clk);
        if (hold_asks != hold_offs)
        begin
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_offs++;
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected word: tag %h price %h action %0d",
                             day_tag_out, close_price_out, action);
                end
            end
            else
            begin
                want = expected_words.pop_front();
                if (day_tag_out !== want.tag || close_price_out !== want.price ||
                    action !== want.act)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected tag %h price %h action %0d,",
                                 want.tag, want.price, want.act,
                                 " got tag %h price %h action %0d",
                                 day_tag_out, close_price_out, action);
                    end
                end
            end
        end
    end

    initial
    begin
        int          r;
        int          c;
        int          i;
        logic [8:0]  short_cfg;
        logic [8:0]  long_cfg;
        int unsigned mag;
        int unsigned pick;
        longint      level;
        longint      step;
        bit          rising;
        bit          go_up;
        logic [31:0] price;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < PLAN_ROWS; r++)
        begin
            if (PLAN[r].kind == ROW_CFG)
            begin
                drain_results();
                write_register(PLAN[r].a[dmac_pkg::IDX_W-1:0],
                               PLAN[r].b[dmac_pkg::CFG_W-1:0]);
            end
            else
            begin
                send_word(PLAN[r].a, PLAN[r].b, PLAN[r].pinned, PLAN[r].act);
            end
        end

        for (c = 0; c < CHUNKS; c++)
        begin
            drain_results();
            if (c == 4)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 35;
            end
            if (c == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (c)
                3:
                begin
                    short_cfg = 9'd1;
                    long_cfg = 9'd256;
                end
                5:
                begin
                    short_cfg = 9'd0;
                    long_cfg = 9'd511;
                end
                7:
                begin
                    short_cfg = 9'd256;
                    long_cfg = 9'd1;
                end
                10:
                begin
                    short_cfg = 9'd300;
                    long_cfg = 9'd0;
                end
                default:
                begin
                    short_cfg = 9'($urandom_range(1, 8));
                    long_cfg = short_cfg + 9'($urandom_range(1, 30));
                end
            endcase
            write_register(dmac_pkg::REG_SHORT_WINDOW, short_cfg);
            write_register(dmac_pkg::REG_LONG_WINDOW, long_cfg);
            if ($urandom_range(3) == 0)
            begin
                write_register($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B,
                               dmac_pkg::CFG_W'($urandom));
            end
            if (c == 0 || c == 8)
            begin
                hold_asks++;
            end
            mag = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom_range(10, 5000);
            level = longint'($urandom);
            rising = $urandom_range(1);
            for (i = 0; i < CHUNK_WORDS; i++)
            begin
                if (i == CHUNK_WORDS / 2 && c % 4 == 2)
                begin
                    drain_results();
                end
                pick = $urandom_range(99);
                if (pick < 5)
                begin
                    price = 32'h0000_0000;
                end
                else if (pick < 10)
                begin
                    price = 32'hFFFF_FFFF;
                end
                else if (pick < 20)
                begin
                    price = $urandom;
                end
                else
                begin
                    step = longint'($urandom_range(0, mag));
                    go_up = ($urandom_range(99) < 75) ? rising : !rising;
                    level = go_up ? level + step : level - step;
                    if (level < 0)
                    begin
                        level = 0;
                    end
                    if (level > 64'sd4294967295)
                    begin
                        level = 64'sd4294967295;
                    end
                    if ($urandom_range(99) < 8)
                    begin
                        rising = !rising;
                    end
                    price = level[31:0];
                end
                send_word(price, $urandom, 1'b0, dmac_pkg::ACT_HOLD);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d price words over %0d window settings (%0d register writes).",
                 words_sent, CHUNKS + 4, config_writes);
        $display("Predicted %0d buys and %0d sells; %0d long output hold-offs; %0d mismatches.",
                 buys, sells, hold_offs, mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
